/* rtl/core/nwl_pkg.sv */
// nwl_pkg: shared constants, types and state encodings for the polygon normal block
// no dependencies; imported by every module under rtl/core
`default_nettype none

package nwl_pkg;

  // polygon limits and coordinate format
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 16;
  localparam int FIELD_W      = 16;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 2);

  // accumulator and Newell term widths
  localparam int SUM_W  = 44;
  localparam int TERM_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * TERM_W;

  // normalizer widths: magnitude split for the shared multiplier, root, remainder
  localparam int MAG_W      = SUM_W;
  localparam int HALF_W     = MAG_W / 2;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ROOT_W     = MAG_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int Q_FRAC     = 14;
  localparam int Q_W        = Q_FRAC + 1;
  localparam int ONE_Q      = 1 << Q_FRAC;
  localparam int DIV_CNT_W  = $clog2(Q_W);
  localparam int N_COMP     = 3;
  localparam int COMP_W     = $clog2(N_COMP);

  // queue of finished polygon sums
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // one finished polygon: the three Newell sums and the overflow mark
  typedef struct packed {
    sum_t sx;
    sum_t sy;
    sum_t sz;
    logic ovf;
  } nwl_sums_t;

  // front to queue
  typedef struct packed {
    logic      push;
    nwl_sums_t data;
  } nwl_push_t;

  // queue to back
  typedef struct packed {
    logic      valid;
    nwl_sums_t data;
  } nwl_head_t;

  typedef enum logic [0:0] {
    FR_RUN,
    FR_CLOSE
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQR,
    BK_SUM,
    BK_ROOT,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  // partial products of one 44-bit square
  typedef enum logic [1:0] {
    SQ_LL,
    SQ_HL,
    SQ_HH
  } sq_part_t;

endpackage

`default_nettype wire

/* rtl/core/newell_polygon_normal.sv */
// newell_polygon_normal: top level, unit polygon normal by Newell's method
// depends on nwl_pkg, nwl_front, nwl_queue, nwl_back
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | vertex_x/y/z, last_vertex
//   out_    | output    | out_valid/out_stall | normal_x/y/z, degenerate, too_many_vertices
//
// front: one vertex per cycle while in_stall is low; a last vertex stalls the input for the
//   closing edge, which waits for a free slot in the four-entry sums queue
// back: nine shared 22x22 multiplies form the sum of squares, then the 44-step square root
//   (one result bit per cycle) and the 15-step divider lanes run in turn
// reset is synchronous and active low; no clearing pass after reset
// a stalled result holds in the output register while the front keeps taking vertices
`default_nettype none

module newell_polygon_normal (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [nwl_pkg::FIELD_W-1:0] in_vertex_x,
  input  logic signed [nwl_pkg::FIELD_W-1:0] in_vertex_y,
  input  logic signed [nwl_pkg::FIELD_W-1:0] in_vertex_z,
  input  logic                               in_last_vertex,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [nwl_pkg::FIELD_W-1:0] out_normal_x,
  output logic signed [nwl_pkg::FIELD_W-1:0] out_normal_y,
  output logic signed [nwl_pkg::FIELD_W-1:0] out_normal_z,
  output logic                               out_degenerate,
  output logic                               out_too_many_vertices
);
  import nwl_pkg::*;

  nwl_push_t          q_push;
  nwl_head_t          q_head;
  logic               q_pop;
  logic [FIELD_W-1:0] nx, ny, nz;

  // vertex intake and accumulation
  nwl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vx         (in_vertex_x),
    .vy         (in_vertex_y),
    .vz         (in_vertex_z),
    .last       (in_last_vertex),
    .credit_ret (q_pop),
    .q_push     (q_push)
  );

  // finished sums waiting for the normalizer
  nwl_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .head   (q_head)
  );

  // normalization and result register
  nwl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_nx         (nx),
    .out_ny         (ny),
    .out_nz         (nz),
    .out_degenerate (out_degenerate),
    .out_too_many   (out_too_many_vertices)
  );

  assign out_normal_x = nx;
  assign out_normal_y = ny;
  assign out_normal_z = nz;

endmodule

`default_nettype wire

/* rtl/core/nwl_front.sv */
// nwl_front: vertex intake, Newell term pipeline and per-polygon accumulators
// depends on nwl_pkg; pushes finished sums into nwl_queue, takes queue credits back
`default_nettype none

module nwl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nwl_pkg::FIELD_W-1:0]  vx,
  input  logic [nwl_pkg::FIELD_W-1:0]  vy,
  input  logic [nwl_pkg::FIELD_W-1:0]  vz,
  input  logic                         last,
  input  logic                         credit_ret,
  output nwl_pkg::nwl_push_t           q_push
);
  import nwl_pkg::*;

  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_VERTICES);

  fr_state_t          st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]  credit_r;
  coord_t             first_x_r, first_y_r, first_z_r;
  coord_t             prev_x_r, prev_y_r, prev_z_r;
  sum_t               sum_x_r, sum_y_r, sum_z_r;

  logic               accept, close_go, edge_ok, s1_go;
  coord_t             x_in, y_in, z_in, bx, by, bz;
  logic signed [TERM_W-1:0] ax_e, ay_e, az_e, bx_e, by_e, bz_e;

  logic                     s1_vld_r, s1_close_r, s1_ovf_r;
  logic signed [TERM_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r, s1_sx_r, s1_sy_r, s1_sz_r;
  logic                     s2_vld_r, s2_close_r, s2_ovf_r;
  logic signed [PROD_W-1:0] s2_px_r, s2_py_r, s2_pz_r;
  sum_t                     sum_x_nxt, sum_y_nxt, sum_z_nxt;

  assign x_in = coord_t'(vx[COORD_BITS-1:0]);
  assign y_in = coord_t'(vy[COORD_BITS-1:0]);
  assign z_in = coord_t'(vz[COORD_BITS-1:0]);

  // intake control: a last vertex adds a closing-edge step, which waits for a queue credit
  always_comb begin
    st_nxt   = st_r;
    accept   = 1'b0;
    close_go = 1'b0;
    in_stall = 1'b1;
    unique case (st_r)
      FR_RUN: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid && last) begin
          st_nxt = FR_CLOSE;
        end
      end
      FR_CLOSE: begin
        if (credit_r != '0) begin
          close_go = 1'b1;
          st_nxt   = FR_RUN;
        end
      end
      default: begin
        st_nxt = FR_RUN;
      end
    endcase
  end

  // an edge is added while the count stays within the limit
  assign edge_ok = accept && (cnt_r != '0) && (cnt_r < MAXC);
  assign s1_go   = edge_ok || close_go;

  // edge end point: new vertex, or the first vertex for the closing edge
  assign bx = close_go ? first_x_r : x_in;
  assign by = close_go ? first_y_r : y_in;
  assign bz = close_go ? first_z_r : z_in;

  assign ax_e = {prev_x_r[COORD_BITS-1], prev_x_r};
  assign ay_e = {prev_y_r[COORD_BITS-1], prev_y_r};
  assign az_e = {prev_z_r[COORD_BITS-1], prev_z_r};
  assign bx_e = {bx[COORD_BITS-1], bx};
  assign by_e = {by[COORD_BITS-1], by};
  assign bz_e = {bz[COORD_BITS-1], bz};

  // accumulate, or close the polygon and hand the sums to the queue
  assign sum_x_nxt = sum_x_r + {{(SUM_W-PROD_W){s2_px_r[PROD_W-1]}}, s2_px_r};
  assign sum_y_nxt = sum_y_r + {{(SUM_W-PROD_W){s2_py_r[PROD_W-1]}}, s2_py_r};
  assign sum_z_nxt = sum_z_r + {{(SUM_W-PROD_W){s2_pz_r[PROD_W-1]}}, s2_pz_r};

  assign q_push.push    = s2_vld_r && s2_close_r;
  assign q_push.data.sx = sum_x_nxt;
  assign q_push.data.sy = sum_y_nxt;
  assign q_push.data.sz = sum_z_nxt;
  assign q_push.data.ovf = s2_ovf_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= FR_RUN;
      cnt_r    <= '0;
      credit_r <= QCNT_W'(QDEPTH);
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_z_r  <= '0;
    end else begin
      st_r     <= st_nxt;
      s1_vld_r <= s1_go;
      s2_vld_r <= s1_vld_r;
      credit_r <= credit_r - QCNT_W'(close_go) + QCNT_W'(credit_ret);
      if (close_go) begin
        cnt_r <= '0;
      end else if (accept && (cnt_r <= MAXC)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (s2_vld_r) begin
        if (s2_close_r) begin
          sum_x_r <= '0;
          sum_y_r <= '0;
          sum_z_r <= '0;
        end else begin
          sum_x_r <= sum_x_nxt;
          sum_y_r <= sum_y_nxt;
          sum_z_r <= sum_z_nxt;
        end
      end
    end
  end

  // vertex registers and term pipeline
  always_ff @(posedge clk) begin
    if (accept && (cnt_r == '0)) begin
      first_x_r <= x_in;
      first_y_r <= y_in;
      first_z_r <= z_in;
    end
    if (accept && ((cnt_r == '0) || (cnt_r < MAXC))) begin
      prev_x_r <= x_in;
      prev_y_r <= y_in;
      prev_z_r <= z_in;
    end
    if (s1_go) begin
      s1_close_r <= close_go;
      s1_ovf_r   <= close_go && (cnt_r > MAXC);
      s1_dx_r    <= ay_e - by_e;
      s1_sx_r    <= az_e + bz_e;
      s1_dy_r    <= az_e - bz_e;
      s1_sy_r    <= ax_e + bx_e;
      s1_dz_r    <= ax_e - bx_e;
      s1_sz_r    <= ay_e + by_e;
    end
    s2_close_r <= s1_close_r;
    s2_ovf_r   <= s1_ovf_r;
    s2_px_r    <= s1_dx_r * s1_sx_r;
    s2_py_r    <= s1_dy_r * s1_sy_r;
    s2_pz_r    <= s1_dz_r * s1_sz_r;
  end

  // credits never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= QCNT_W'(QDEPTH))
    else $error("queue credit above depth");

  // closing edge is issued only with a credit in hand
  a_close_credit: assert property (@(posedge clk) disable iff (!rst_n)
    close_go |-> (credit_r != '0))
    else $error("closing edge without credit");

endmodule

`default_nettype wire

/* rtl/core/nwl_queue.sv */
// nwl_queue: short FIFO of finished polygon sums between front and back
// depends on nwl_pkg; fed by nwl_front, drained by nwl_back
`default_nettype none

module nwl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  nwl_pkg::nwl_push_t q_push,
  input  logic               pop,
  output nwl_pkg::nwl_head_t head
);
  import nwl_pkg::*;

  nwl_sums_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  assign head.valid = (cnt_r != '0);
  assign head.data  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(q_push.push) - QCNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.data;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> (cnt_r != QCNT_W'(QDEPTH)) || pop)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/core/nwl_back.sv */
// nwl_back: normalizer - sum of squares, integer square root, three divider lanes
// depends on nwl_pkg; takes sums from nwl_queue, drives the result register
`default_nettype none

module nwl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nwl_pkg::nwl_head_t          head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nwl_pkg::FIELD_W-1:0] out_nx,
  output logic [nwl_pkg::FIELD_W-1:0] out_ny,
  output logic [nwl_pkg::FIELD_W-1:0] out_nz,
  output logic                        out_degenerate,
  output logic                        out_too_many
);
  import nwl_pkg::*;

  localparam logic [COMP_W-1:0]     LAST_COMP = COMP_W'(N_COMP - 1);
  localparam logic [ROOT_CNT_W-1:0] LAST_ROOT = ROOT_CNT_W'(ROOT_W - 1);
  localparam logic [DIV_CNT_W-1:0]  LAST_DIV  = DIV_CNT_W'(Q_W - 1);
  localparam logic [Q_W-1:0]        ONE_QV    = Q_W'(ONE_Q);

  bk_state_t            st_r, st_nxt;
  logic                 sq_issue, out_load;

  logic [MAG_W-1:0]     mag_r [N_COMP];
  logic                 neg_r [N_COMP];
  logic                 ovf_r;
  logic [COMP_W-1:0]    comp_r;
  sq_part_t             part_r, prod_part_r;
  logic                 prod_vld_r;
  logic [2*HALF_W-1:0]  prod_r;
  logic [SQ_W-1:0]      sq_r, sq_add;
  logic [HALF_W-1:0]    mul_a, mul_b;
  logic [MAG_W-1:0]     mag_sel;

  logic [REM_W-1:0]     rem_r, rem_sh, trial;
  logic [ROOT_W-1:0]    root_r;
  logic [ROOT_CNT_W-1:0] rcnt_r;

  logic [MAG_W:0]       drem_r [N_COMP];
  logic [MAG_W:0]       dt     [N_COMP];
  logic [Q_W-1:0]       dq_r   [N_COMP];
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic [MAG_W:0]       len_e;
  logic [FIELD_W-1:0]   comp_val [N_COMP];

  logic                 out_valid_r, out_deg_r, out_tmv_r;
  logic [FIELD_W-1:0]   out_nx_r, out_ny_r, out_nz_r;

  // sequencer: pop, squares, root, divide, result; an overflow mark goes straight to the result
  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    sq_issue = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (head.valid) begin
          pop    = 1'b1;
          st_nxt = head.data.ovf ? BK_OUT : BK_SQR;
        end
      end
      BK_SQR: begin
        sq_issue = 1'b1;
        if ((comp_r == LAST_COMP) && (part_r == SQ_HH)) begin
          st_nxt = BK_SUM;
        end
      end
      BK_SUM: begin
        st_nxt = BK_ROOT;
      end
      BK_ROOT: begin
        if (rcnt_r == LAST_ROOT) begin
          st_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (dcnt_r == LAST_DIV) begin
          st_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  // shared 22x22 multiplier operands
  assign mag_sel = mag_r[comp_r];
  assign mul_a   = (part_r == SQ_LL) ? mag_sel[HALF_W-1:0] : mag_sel[MAG_W-1:HALF_W];
  assign mul_b   = (part_r == SQ_HH) ? mag_sel[MAG_W-1:HALF_W] : mag_sel[HALF_W-1:0];

  // place the registered partial product: cross term counts twice
  always_comb begin
    unique case (prod_part_r)
      SQ_LL:   sq_add = SQ_W'(prod_r);
      SQ_HL:   sq_add = SQ_W'(prod_r) << (HALF_W + 1);
      SQ_HH:   sq_add = SQ_W'(prod_r) << (2 * HALF_W);
      default: sq_add = '0;
    endcase
  end

  // root step: bring down two bits, try root*4+1
  assign rem_sh = {rem_r[REM_W-3:0], sq_r[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});

  // divider lanes: shift after the first step, compare against the root
  assign len_e = (MAG_W + 1)'(root_r);
  always_comb begin
    for (int c = 0; c < N_COMP; c++) begin
      dt[c] = (dcnt_r == '0) ? drem_r[c] : {drem_r[c][MAG_W-1:0], 1'b0};
    end
  end

  // signed, saturated Q1.14 components
  always_comb begin
    for (int c = 0; c < N_COMP; c++) begin
      logic [Q_W-1:0] qs;
      qs = (dq_r[c] > ONE_QV) ? ONE_QV : dq_r[c];
      comp_val[c] = neg_r[c] ? (FIELD_W'(0) - FIELD_W'(qs)) : FIELD_W'(qs);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      prod_vld_r <= sq_issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      neg_r[0] <= head.data.sx[SUM_W-1];
      neg_r[1] <= head.data.sy[SUM_W-1];
      neg_r[2] <= head.data.sz[SUM_W-1];
      mag_r[0] <= head.data.sx[SUM_W-1] ? MAG_W'(-head.data.sx) : MAG_W'(head.data.sx);
      mag_r[1] <= head.data.sy[SUM_W-1] ? MAG_W'(-head.data.sy) : MAG_W'(head.data.sy);
      mag_r[2] <= head.data.sz[SUM_W-1] ? MAG_W'(-head.data.sz) : MAG_W'(head.data.sz);
      ovf_r    <= head.data.ovf;
      comp_r   <= '0;
      part_r   <= SQ_LL;
      sq_r     <= '0;
    end
    if (sq_issue) begin
      prod_r      <= mul_a * mul_b;
      prod_part_r <= part_r;
      unique case (part_r)
        SQ_LL: part_r <= SQ_HL;
        SQ_HL: part_r <= SQ_HH;
        SQ_HH: begin
          part_r <= SQ_LL;
          comp_r <= comp_r + 1'b1;
        end
        default: part_r <= SQ_LL;
      endcase
    end
    if (prod_vld_r) begin
      sq_r <= sq_r + sq_add;
    end
    if (st_r == BK_SUM) begin
      rem_r  <= '0;
      root_r <= '0;
      rcnt_r <= '0;
    end
    if (st_r == BK_ROOT) begin
      sq_r   <= sq_r << 2;
      rcnt_r <= rcnt_r + 1'b1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
      if (rcnt_r == LAST_ROOT) begin
        dcnt_r <= '0;
        for (int c = 0; c < N_COMP; c++) begin
          drem_r[c] <= (MAG_W + 1)'(mag_r[c]);
          dq_r[c]   <= '0;
        end
      end
    end
    if (st_r == BK_DIV) begin
      dcnt_r <= dcnt_r + 1'b1;
      for (int c = 0; c < N_COMP; c++) begin
        if (dt[c] >= len_e) begin
          drem_r[c] <= dt[c] - len_e;
          dq_r[c]   <= {dq_r[c][Q_W-2:0], 1'b1};
        end else begin
          drem_r[c] <= dt[c];
          dq_r[c]   <= {dq_r[c][Q_W-2:0], 1'b0};
        end
      end
    end
    // result register
    if (out_load) begin
      if (ovf_r) begin
        out_nx_r  <= '0;
        out_ny_r  <= '0;
        out_nz_r  <= '0;
        out_deg_r <= 1'b0;
        out_tmv_r <= 1'b1;
      end else if (root_r == '0) begin
        out_nx_r  <= '0;
        out_ny_r  <= '0;
        out_nz_r  <= '0;
        out_deg_r <= 1'b1;
        out_tmv_r <= 1'b0;
      end else begin
        out_nx_r  <= comp_val[0];
        out_ny_r  <= comp_val[1];
        out_nz_r  <= comp_val[2];
        out_deg_r <= 1'b0;
        out_tmv_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_nx         = out_nx_r;
  assign out_ny         = out_ny_r;
  assign out_nz         = out_nz_r;
  assign out_degenerate = out_deg_r;
  assign out_too_many   = out_tmv_r;

  // a flagged result carries a zero normal
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_deg_r || out_tmv_r) |->
      (out_nx_r == '0) && (out_ny_r == '0) && (out_nz_r == '0))
    else $error("flagged result with nonzero normal");

  // a new item is taken from the queue only while no polygon is in work
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (st_r == BK_IDLE))
    else $error("queue pop while busy");

endmodule

`default_nettype wire

/* dv/tb.sv */
// tb: self-checking bench for newell_polygon_normal, vertex stream in, unit normals out
// depends on nwl_pkg and the newell_polygon_normal rtl; the expected normal of each
// polygon is computed in-bench with exact integer arithmetic and compared field by field
`default_nettype none

module tb;
  import nwl_pkg::*;

  localparam int LIMIT        = 500000;
  localparam int HOLD_AT      = 80;
  localparam int HOLD_CYCLES  = 1500;
  localparam int RANDOM_ITEMS = 380;
  localparam int TAIL_CYCLES  = 300;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } vertex_t;

  typedef struct packed {
    coord_t nx;
    coord_t ny;
    coord_t nz;
    logic   degen;
    logic   ovf;
  } normal_t;

  // polygon shapes for the random part
  typedef enum int {
    SHAPE_FULL,
    SHAPE_TINY,
    SHAPE_FLAT,
    SHAPE_EDGES
  } shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_vertex_x = '0;
  coord_t in_vertex_y = '0;
  coord_t in_vertex_z = '0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_normal_x;
  coord_t out_normal_y;
  coord_t out_normal_z;
  logic out_degenerate;
  logic out_too_many_vertices;

  vertex_t vertex_feed[$];
  normal_t expected_normals[$];

  int vertices_taken = 0;
  int polygons_sent = 0;
  int normals_checked = 0;
  int degenerate_seen = 0;
  int overflow_seen = 0;
  int errors = 0;
  int cycles = 0;
  int idle_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic quiet;

  // polygon state of the predictor
  coord_t first_x = '0, first_y = '0, first_z = '0;
  coord_t prev_x = '0, prev_y = '0, prev_z = '0;
  sum_t acc_x = '0, acc_y = '0, acc_z = '0;
  int unsigned vcount = 0;

  always #4 clk = ~clk;

  newell_polygon_normal u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_vertex_x           (in_vertex_x),
    .in_vertex_y           (in_vertex_y),
    .in_vertex_z           (in_vertex_z),
    .in_last_vertex        (in_last_vertex),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_normal_x          (out_normal_x),
    .out_normal_y          (out_normal_y),
    .out_normal_z          (out_normal_z),
    .out_degenerate        (out_degenerate),
    .out_too_many_vertices (out_too_many_vertices)
  );

  // stretches in which no new input gaps or random result stalls are drawn
  assign quiet = ((vertices_taken / 80) % 3) == 1;

  // newell terms of one edge a -> b, sums wrap at the accumulator width
  function automatic void add_newell_edge(coord_t ax, coord_t ay, coord_t az,
                                          coord_t bx, coord_t by, coord_t bz);
    longint tx, ty, tz;
    tx = (longint'(ay) - longint'(by)) * (longint'(az) + longint'(bz));
    ty = (longint'(az) - longint'(bz)) * (longint'(ax) + longint'(bx));
    tz = (longint'(ax) - longint'(bx)) * (longint'(ay) + longint'(by));
    acc_x = acc_x + tx[SUM_W-1:0];
    acc_y = acc_y + ty[SUM_W-1:0];
    acc_z = acc_z + tz[SUM_W-1:0];
  endfunction

  function automatic logic [127:0] square_of(sum_t v);
    longint a;
    logic [127:0] m;
    a = v;
    m = (a < 0) ? -a : a;
    return m * m;
  endfunction

  // floor of the square root, one result bit at a time
  function automatic longint unsigned floor_root(logic [127:0] s);
    longint unsigned r, c;
    logic [127:0] w;
    r = 0;
    for (int b = 45; b >= 0; b--) begin
      c = r | (64'd1 << b);
      w = c;
      if (w * w <= s) r = c;
    end
    return r;
  endfunction

  // trunc(acc * 2^14 / len), clipped to one in q1.14
  function automatic coord_t unit_component(sum_t acc, longint unsigned len);
    longint a, v;
    longint unsigned q;
    a = acc;
    q = (longint'((a < 0) ? -a : a) << 14) / len;
    if (q > ONE_Q) q = ONE_Q;
    v = (a < 0) ? -longint'(q) : longint'(q);
    return v[FIELD_W-1:0];
  endfunction

  // advance the polygon state by one vertex; 1 when a normal is due
  function automatic bit newell_step(input vertex_t v, output normal_t res);
    logic [127:0] s;
    longint unsigned len;
    res = '0;
    if (vcount == 0) begin
      first_x = v.x;
      first_y = v.y;
      first_z = v.z;
      prev_x = v.x;
      prev_y = v.y;
      prev_z = v.z;
      vcount = 1;
    end else if (vcount <= MAX_VERTICES) begin
      vcount++;
      if (vcount <= MAX_VERTICES) begin
        add_newell_edge(prev_x, prev_y, prev_z, v.x, v.y, v.z);
        prev_x = v.x;
        prev_y = v.y;
        prev_z = v.z;
      end
    end
    if (!v.last) return 1'b0;
    if (vcount > MAX_VERTICES) begin
      res.ovf = 1'b1;
    end else begin
      add_newell_edge(prev_x, prev_y, prev_z, first_x, first_y, first_z);
      s = square_of(acc_x) + square_of(acc_y) + square_of(acc_z);
      len = floor_root(s);
      if (len == 0) begin
        res.degen = 1'b1;
      end else begin
        res.nx = unit_component(acc_x, len);
        res.ny = unit_component(acc_y, len);
        res.nz = unit_component(acc_z, len);
      end
    end
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    vcount = 0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic push_vertex(int x, int y, int z, bit last);
    vertex_t v;
    v.x = x[FIELD_W-1:0];
    v.y = y[FIELD_W-1:0];
    v.z = z[FIELD_W-1:0];
    v.last = last;
    vertex_feed.insert(vertex_feed.size(), v);
    if (last) polygons_sent++;
  endtask

  function automatic int edge_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic add_polygon(int n, shape_t shape);
    int flat_z;
    flat_z = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_TINY:
          push_vertex($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                      $urandom_range(0, 6) - 3, i == n - 1);
        SHAPE_FLAT:
          push_vertex($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                      flat_z, i == n - 1);
        SHAPE_EDGES:
          push_vertex(edge_coord(), edge_coord(), edge_coord(), i == n - 1);
        default:
          push_vertex($urandom, $urandom, $urandom, i == n - 1);
      endcase
    end
  endtask

  // input driver: one transaction per pop, payload held while stalled
  always @(posedge clk) begin : drive_vertices
    vertex_t cur;
    normal_t nrm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        vertices_taken <= vertices_taken + 1;
        if (newell_step(cur, nrm)) expected_normals.insert(expected_normals.size(), nrm);
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          in_valid <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (vertex_feed.size() != 0) begin
          cur = vertex_feed.pop_front();
          in_vertex_x <= cur.x;
          in_vertex_y <= cur.y;
          in_vertex_z <= cur.z;
          in_last_vertex <= cur.last;
          in_valid <= 1'b1;
          idle_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure, with one long hold-off to fill the block
  always @(posedge clk) begin : drive_stall
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && vertices_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(10, 60);
      end
    end
  end

  // result monitor: compare each transaction with the oldest expected normal
  always @(posedge clk) begin : check_normals
    normal_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_normals.size() == 0) begin
        $error("normal with no polygon pending: x %0d y %0d z %0d",
               out_normal_x, out_normal_y, out_normal_z);
        errors++;
      end else begin
        want = expected_normals.pop_front();
        normals_checked++;
        if (out_normal_x !== want.nx) begin
          $error("normal_x: expected %0d, got %0d", want.nx, out_normal_x);
          errors++;
        end
        if (out_normal_y !== want.ny) begin
          $error("normal_y: expected %0d, got %0d", want.ny, out_normal_y);
          errors++;
        end
        if (out_normal_z !== want.nz) begin
          $error("normal_z: expected %0d, got %0d", want.nz, out_normal_z);
          errors++;
        end
        if (out_degenerate !== want.degen) begin
          $error("degenerate: expected %0d, got %0d", want.degen, out_degenerate);
          errors++;
        end
        if (out_too_many_vertices !== want.ovf) begin
          $error("too_many_vertices: expected %0d, got %0d", want.ovf,
                 out_too_many_vertices);
          errors++;
        end
        if (want.degen) degenerate_seen++;
        if (want.ovf) overflow_seen++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus, then drain and report
  initial begin : stimulus
    int random_items;
    int polygon_idx;
    int n;
    // single vertex, closing edge adds nothing
    push_vertex(32767, 32767, 32767, 1'b1);
    // vertex pair, the edge there and the edge back cancel
    push_vertex(-32768, -32768, -32768, 1'b0);
    push_vertex(32767, 32767, 32767, 1'b1);
    // axis normals, both windings
    push_vertex(0, 0, 0, 1'b0);
    push_vertex(100, 0, 0, 1'b0);
    push_vertex(0, 100, 0, 1'b1);
    push_vertex(0, 0, 0, 1'b0);
    push_vertex(0, 100, 0, 1'b0);
    push_vertex(100, 0, 0, 1'b1);
    push_vertex(0, 0, 0, 1'b0);
    push_vertex(0, 7, 0, 1'b0);
    push_vertex(0, 0, 7, 1'b1);
    push_vertex(0, 0, 0, 1'b0);
    push_vertex(0, 0, -5, 1'b0);
    push_vertex(-5, 0, 0, 1'b1);
    // coordinate extremes
    push_vertex(-32768, -32768, -32768, 1'b0);
    push_vertex(32767, -32768, 32767, 1'b0);
    push_vertex(-32768, 32767, 32767, 1'b1);
    // collinear, zero area
    push_vertex(1, 2, 3, 1'b0);
    push_vertex(2, 4, 6, 1'b0);
    push_vertex(3, 6, 9, 1'b1);

    // random polygons, with one just past the vertex limit
    random_items = 0;
    polygon_idx = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (polygon_idx == 20) begin
        add_polygon(MAX_VERTICES + 1, SHAPE_TINY);
        random_items += MAX_VERTICES + 1;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      add_polygon(n, shape_t'($urandom_range(0, 3)));
      random_items += n;
      polygon_idx++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (vertex_feed.size() != 0 || in_valid) @(posedge clk);
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d vertices in %0d polygons, %0d normals checked",
             vertices_taken, polygons_sent, normals_checked);
    $display("of those %0d degenerate and %0d over the vertex limit",
             degenerate_seen, overflow_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* newell_polygon_normal.f */
rtl/core/nwl_pkg.sv
rtl/core/nwl_front.sv
rtl/core/nwl_queue.sv
rtl/core/nwl_back.sv
rtl/core/newell_polygon_normal.sv
dv/tb.sv
